[sv/tsg_pkg.sv]
// ----------------------------------------------------------------------------
// tsg_pkg: shared types and constants of the setpoint generator
// Holds the register map, sequencer states, trig unit request and response
// types and the quarter-wave sine and cosine tables, built at elaboration.
// ----------------------------------------------------------------------------
package tsg_pkg;

    // Sine table resolution (steps per turn) and position saturation width
    localparam int SINE_TABLE_ENTRIES = 1024;
    localparam int POSITION_WIDTH     = 32;

    // Phase bits used by the circle; the half yaw angle needs one bit more
    localparam int PHASE_BITS = $clog2(SINE_TABLE_ENTRIES);
    localparam int HALF_BITS  = PHASE_BITS + 1;
    localparam int FINE_BITS  = HALF_BITS - 2;
    localparam int TAB_BITS   = FINE_BITS - 1;
    localparam int TAB_DEPTH  = 2 ** TAB_BITS;

    // Fixed point constants of the series evaluation
    localparam longint Q30_ONE     = 64'sd1 << 30;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint SIN_DENS [6] = '{156, 110, 72, 42, 20, 6};
    localparam longint COS_DENS [6] = '{132, 90, 56, 30, 12, 2};

    // Mode codes
    localparam logic [1:0] MODE_HOVER  = 2'd0;
    localparam logic [1:0] MODE_CIRCLE = 2'd1;
    localparam logic [1:0] MODE_LINE   = 2'd2;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_MODE        = 3'd0;
    localparam logic [2:0] REG_CENTER_X    = 3'd1;
    localparam logic [2:0] REG_CENTER_Y    = 3'd2;
    localparam logic [2:0] REG_CENTER_Z    = 3'd3;
    localparam logic [2:0] REG_RADIUS      = 3'd4;
    localparam logic [2:0] REG_MOTION_STEP = 3'd5;
    localparam logic [2:0] REG_LINE_LENGTH = 3'd6;
    localparam logic [2:0] REG_START_DELAY = 3'd7;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,
        S_STEP,
        S_TRIG_POS,
        S_TRIG_HALF,
        S_MUL_X,
        S_MUL_Y,
        S_RND_Y,
        S_ADD_Y,
        S_LINE,
        S_EMIT
    } tsg_state_t;

    // Trig unit request: angle in 2^-HALF_BITS turns
    typedef struct packed {
        logic                 en;
        logic [HALF_BITS-1:0] turn;
    } trig_req_t;

    // Trig unit response: Q30 sine and cosine
    typedef struct packed {
        logic signed [31:0] s;
        logic signed [31:0] c;
    } trig_resp_t;

    // One quarter-wave entry: {sin, cos}, each Q30 in 0..1
    typedef logic [61:0] tab_t [TAB_DEPTH];

    function automatic longint clamp_q30(longint v);
        longint r;
        r = v;
        if (v < 0) r = 0;
        if (v > Q30_ONE) r = Q30_ONE;
        return r;
    endfunction

    // Series evaluation of sin and cos at fine step number fine in the quarter
    function automatic logic [61:0] sincos_entry(int fine);
        longint u;
        longint x;
        longint x2;
        longint t;
        longint s;
        longint c;
        int     k;
        u = longint'(fine) << (30 - FINE_BITS);
        x = u * HALF_PI_Q30 / Q30_ONE;
        x2 = x * x / Q30_ONE;
        t = Q30_ONE;
        for (k = 0; k < 6; k++)
        begin
            t = Q30_ONE - (x2 * t / Q30_ONE) / SIN_DENS[k];
        end
        s = clamp_q30(x * t / Q30_ONE);
        t = Q30_ONE;
        for (k = 0; k < 6; k++)
        begin
            t = Q30_ONE - (x2 * t / Q30_ONE) / COS_DENS[k];
        end
        c = clamp_q30(t);
        return {s[30:0], c[30:0]};
    endfunction

    // Even or odd fine steps of the quarter wave
    function automatic tab_t build_tab(int odd);
        tab_t tab;
        int   i;
        for (i = 0; i < TAB_DEPTH; i++)
        begin
            tab[i] = sincos_entry(2 * i + odd);
        end
        return tab;
    endfunction

    localparam tab_t EVEN_TAB = build_tab(0);
    localparam tab_t ODD_TAB  = build_tab(1);

endpackage

[sv/tsg_trig.sv]
// ----------------------------------------------------------------------------
// tsg_trig: shared sine and cosine unit
// Looks up the quarter-wave tables and folds the result into the quadrant
// of the requested angle. Registered output, one request per cycle.
// ----------------------------------------------------------------------------
module tsg_trig
    import tsg_pkg::*;
(
    input  logic       clk,
    input  trig_req_t  req,
    output trig_resp_t resp
);

    logic [1:0]           quad;
    logic [FINE_BITS-1:0] fine;
    logic [61:0]          entry;
    logic signed [31:0]   qs;
    logic signed [31:0]   qc;
    trig_resp_t           resp_next;

    // Table read: even and odd fine steps live in separate tables
    assign quad = req.turn[HALF_BITS-1 -: 2];
    assign fine = req.turn[FINE_BITS-1:0];

    always_comb
    begin
        if (fine[0])
            entry = ODD_TAB[fine[FINE_BITS-1:1]];
        else
            entry = EVEN_TAB[fine[FINE_BITS-1:1]];
    end

    assign qs = $signed({1'b0, entry[61:31]});
    assign qc = $signed({1'b0, entry[30:0]});

    // Quadrant fold
    always_comb
    begin
        case (quad)
            2'd0:
            begin
                resp_next.s = qs;
                resp_next.c = qc;
            end
            2'd1:
            begin
                resp_next.s = qc;
                resp_next.c = -qs;
            end
            2'd2:
            begin
                resp_next.s = -qs;
                resp_next.c = -qc;
            end
            default:
            begin
                resp_next.s = -qc;
                resp_next.c = qs;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (req.en)
            resp <= resp_next;
    end

endmodule

[sv/trajectory_setpoint_generator_top.sv]
// ----------------------------------------------------------------------------
// trajectory_setpoint_generator_top: hover, circle and line setpoint source
// Keeps the timeline (tick count, phase, line distance) and turns each tick
// into a position and yaw quaternion through one trig unit and one multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis_*: one request per publish tick, tdata[0] = restart.
//   A restart request zeroes the timeline and produces no output. An ordinary
//   tick advances the timeline and, once the start delay has run out, gives
//   one output request on m_axis_* (position x/y/z Q16.16, quat_z, quat_w).
//   Registers are to be written through the APB port only while the block is idle; the block does not enforce this.
// Sequence:
//   Ticks that produce nothing end after S_STEP; hover and line ticks then
//   pass S_LINE and S_EMIT, circle ticks S_TRIG_POS to S_ADD_Y and S_EMIT:
//   the shared trig tables are read twice and the single 31x32 multiplier
//   runs twice in series. After a line length change that leaves the distance
//   out of range, the first tick runs the bit-serial remainder (S_MOD) first.
//   s_axis_tready is high only while the sequencer is idle.
// Reset and stall:
//   rst_n clears the timeline and restores the register defaults.
//   The output register holds a result while m_axis_tready is low; the next
//   tick is still accepted and waits in its last step until the register frees.
// ----------------------------------------------------------------------------
module trajectory_setpoint_generator_top
    import tsg_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // Tick stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [0] restart, [7:1] zero
    // Setpoint stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // pos_x, pos_y, pos_z, quat_z, quat_w, pad
    // Register port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    // Configuration registers
    logic [1:0]         mode_reg;
    logic signed [31:0] center_x_reg;
    logic signed [31:0] center_y_reg;
    logic signed [31:0] center_z_reg;
    logic [29:0]        radius_reg;
    logic [31:0]        motion_step_reg;
    logic [29:0]        line_length_reg;
    logic [31:0]        start_delay_reg;

    // Timeline and sequencer
    tsg_state_t  state_reg;
    tsg_state_t  state_next;
    logic [31:0] elapsed_reg;
    logic [31:0] phase_reg;
    logic [31:0] dist_reg;
    logic [30:0] rem_reg;
    logic [4:0]  cnt_reg;

    // Datapath payload
    logic signed [31:0] sin_reg;
    logic signed [31:0] cos_reg;
    logic signed [31:0] hsin_reg;
    logic signed [31:0] hcos_reg;
    logic signed [62:0] prod_reg;
    logic signed [31:0] rnd_reg;
    logic [31:0]        posx_reg;
    logic [31:0]        posy_reg;
    logic               m_valid_reg;
    logic [127:0]       m_data_reg;

    // Control from the output decoder
    logic take;
    logic mod_run;
    logic step_run;
    logic cap_pos;
    logic cap_half;
    logic mul_en;
    logic mul_sin;
    logic rnd_en;
    logic add_x;
    logic add_y;
    logic emit_load;
    logic trig_half;

    trig_req_t  trig_req;
    trig_resp_t trig_resp;

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------
    function automatic logic [31:0] sat_pos(logic signed [32:0] v);
        longint hi;
        longint lo;
        longint w;
        logic [31:0] r;
        hi = (64'sd1 <<< (POSITION_WIDTH - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        w  = longint'(v);
        r  = v[31:0];
        if (w > hi) r = hi[31:0];
        if (w < lo) r = lo[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] round_q30(logic signed [62:0] v);
        logic [62:0] m;
        logic [62:0] t;
        logic [31:0] r;
        m = v[62] ? 63'(-v) : 63'(v);
        t = (m + (63'd1 << 29)) >> 30;
        r = t[31:0];
        return v[62] ? $signed(-r) : $signed(r);
    endfunction

    // Q30 to Q1.15 rounded half away from zero, saturated to 16 bits
    function automatic logic signed [15:0] round_q15(logic signed [31:0] v);
        logic [31:0] m;
        logic [31:0] t;
        logic [15:0] r;
        m = v[31] ? 32'(-v) : 32'(v);
        t = (m + 32'd16384) >> 15;
        if (!v[31])
            r = (t > 32'd32767) ? 16'sd32767 : t[15:0];
        else
            r = (t > 32'd32768) ? 16'h8000 : 16'(-t);
        return $signed(r);
    endfunction

    // ------------------------------------------------------------------------
    // Line geometry
    // ------------------------------------------------------------------------
    logic [29:0] len;
    logic [31:0] two_len;
    logic [31:0] lstep;
    logic [32:0] dsum;
    logic [31:0] dstep;
    logic [31:0] half_len;
    logic [31:0] line_off;

    assign len     = (line_length_reg == 30'd0) ? 30'd1 : line_length_reg;
    assign two_len = {1'b0, len, 1'b0};
    assign lstep   = (motion_step_reg < two_len) ? motion_step_reg : two_len - 32'd1;
    assign dsum    = {1'b0, dist_reg} + {1'b0, lstep};
    assign dstep   = (dsum >= {1'b0, two_len}) ? 32'(dsum - {1'b0, two_len}) : dsum[31:0];
    assign half_len = {3'b0, len[29:1]};
    assign line_off = (dist_reg <= {2'b0, len}) ? dist_reg - half_len
                                                : two_len - dist_reg - half_len;

    // Bit-serial remainder step
    logic [31:0] rem_try;
    logic [30:0] rem_new;

    assign rem_try = {rem_reg, dist_reg[31]};
    assign rem_new = (rem_try >= two_len) ? 31'(rem_try - two_len) : rem_try[30:0];

    // Tick count and emit decision
    logic [31:0] elapsed_inc;
    logic        emit_now;

    assign elapsed_inc = (elapsed_reg < start_delay_reg) ? elapsed_reg + 32'd1
                                                         : start_delay_reg;
    assign emit_now    = (elapsed_inc >= start_delay_reg);

    // ------------------------------------------------------------------------
    // Angles
    // ------------------------------------------------------------------------
    logic [PHASE_BITS-1:0] k_idx;
    logic [31:0]           yaw;
    logic [31:0]           half_yaw;

    assign k_idx = phase_reg[31 -: PHASE_BITS];
    assign yaw   = {k_idx, {(32 - PHASE_BITS){1'b0}}} + 32'h4000_0000;

    always_comb
    begin
        if (yaw == 32'h8000_0000)
            half_yaw = 32'h4000_0000;
        else if (!yaw[31])
            half_yaw = yaw >> 1;
        else
            half_yaw = 32'd0 - ((32'd0 - yaw) >> 1);
    end

    assign trig_req.en   = cap_pos | cap_half;
    assign trig_req.turn = trig_half ? half_yaw[31 -: HALF_BITS] : {k_idx, 1'b0};

    tsg_trig u_trig (
        .clk  (clk),
        .req  (trig_req),
        .resp (trig_resp)
    );

    // ------------------------------------------------------------------------
    // Shared multiplier and saturating adder
    // ------------------------------------------------------------------------
    logic signed [31:0] mul_b;
    logic signed [62:0] mul_p;
    logic signed [31:0] add_a;
    logic signed [31:0] add_b;
    logic [31:0]        add_q;

    assign mul_b = mul_sin ? sin_reg : cos_reg;
    assign mul_p = $signed({1'b0, radius_reg}) * mul_b;

    assign add_a = add_y ? center_y_reg : center_x_reg;
    always_comb
    begin
        if (state_reg == S_LINE)
            add_b = (mode_reg == MODE_LINE) ? $signed(line_off) : 32'sd0;
        else
            add_b = rnd_reg;
    end
    assign add_q = sat_pos(33'(add_a) + 33'(add_b));

    // ------------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid && !s_axis_tdata[0])
                    state_next = (dist_reg >= two_len) ? S_MOD : S_STEP;
            end
            S_MOD:
            begin
                if (cnt_reg == 5'd0)
                    state_next = S_STEP;
            end
            S_STEP:
            begin
                if (!emit_now)
                    state_next = S_IDLE;
                else if (mode_reg == MODE_CIRCLE)
                    state_next = S_TRIG_POS;
                else
                    state_next = S_LINE;
            end
            S_TRIG_POS:  state_next = S_TRIG_HALF;
            S_TRIG_HALF: state_next = S_MUL_X;
            S_MUL_X:     state_next = S_MUL_Y;
            S_MUL_Y:     state_next = S_RND_Y;
            S_RND_Y:     state_next = S_ADD_Y;
            S_ADD_Y:     state_next = S_EMIT;
            S_LINE:      state_next = S_EMIT;
            S_EMIT:
            begin
                if (!m_valid_reg || m_axis_tready)
                    state_next = S_IDLE;
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------------
    always_comb
    begin
        s_axis_tready = 1'b0;
        mod_run       = 1'b0;
        step_run      = 1'b0;
        cap_pos       = 1'b0;
        cap_half      = 1'b0;
        trig_half     = 1'b0;
        mul_en        = 1'b0;
        mul_sin       = 1'b0;
        rnd_en        = 1'b0;
        add_x         = 1'b0;
        add_y         = 1'b0;
        emit_load     = 1'b0;
        case (state_reg)
            S_IDLE:      s_axis_tready = 1'b1;
            S_MOD:       mod_run = 1'b1;
            S_STEP:      step_run = 1'b1;
            S_TRIG_POS:  cap_pos = 1'b1;
            S_TRIG_HALF:
            begin
                cap_half  = 1'b1;
                trig_half = 1'b1;
            end
            S_MUL_X:     mul_en = 1'b1;
            S_MUL_Y:
            begin
                mul_en  = 1'b1;
                mul_sin = 1'b1;
                rnd_en  = 1'b1;
            end
            S_RND_Y:
            begin
                rnd_en = 1'b1;
                add_x  = 1'b1;
            end
            S_ADD_Y:     add_y = 1'b1;
            S_LINE:      add_x = 1'b1;
            S_EMIT:      emit_load = !m_valid_reg || m_axis_tready;
            default:     s_axis_tready = 1'b0;
        endcase
    end

    assign take = s_axis_tvalid & s_axis_tready;

    // ------------------------------------------------------------------------
    // Control state and timeline
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            elapsed_reg <= 32'd0;
            phase_reg   <= 32'd0;
            dist_reg    <= 32'd0;
            rem_reg     <= 31'd0;
            cnt_reg     <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (take)
            begin
                rem_reg <= 31'd0;
                cnt_reg <= 5'd31;
                if (s_axis_tdata[0])
                begin
                    elapsed_reg <= 32'd0;
                    phase_reg   <= 32'd0;
                    dist_reg    <= 32'd0;
                end
                else
                begin
                    phase_reg <= phase_reg + motion_step_reg;
                end
            end
            if (mod_run)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                    dist_reg <= {1'b0, rem_new};
                else
                begin
                    rem_reg  <= rem_new;
                    dist_reg <= {dist_reg[30:0], 1'b0};
                end
            end
            if (step_run)
            begin
                dist_reg    <= dstep;
                elapsed_reg <= elapsed_inc;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (cap_half)
        begin
            sin_reg <= trig_resp.s;
            cos_reg <= trig_resp.c;
        end
        if (state_reg == S_MUL_X)
        begin
            hsin_reg <= trig_resp.s;
            hcos_reg <= trig_resp.c;
        end
        if (mul_en)
            prod_reg <= mul_p;
        if (rnd_en)
            rnd_reg <= round_q30(prod_reg);
        if (add_x)
            posx_reg <= add_q;
        if (add_y)
            posy_reg <= add_q;
    end

    // ------------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------------
    logic [31:0]        out_x;
    logic [31:0]        out_y;
    logic [31:0]        out_z;
    logic signed [15:0] out_qz;
    logic signed [15:0] qw_full;
    logic [14:0]        out_qw;

    assign qw_full = round_q15(hcos_reg);
    assign out_x   = posx_reg;
    assign out_y   = (mode_reg == MODE_CIRCLE) ? posy_reg : sat_pos(33'(center_y_reg));
    assign out_z   = sat_pos(33'(center_z_reg));
    assign out_qz  = (mode_reg == MODE_CIRCLE) ? round_q15(hsin_reg) : 16'sd0;
    assign out_qw  = (mode_reg != MODE_CIRCLE) ? 15'h7FFF :
                     (qw_full[15] ? 15'd0 : qw_full[14:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (emit_load)
            m_valid_reg <= 1'b1;
        else if (m_axis_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
            m_data_reg <= {1'b0, out_qw, out_qz, out_z, out_y, out_x};
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // ------------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------------
    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_HOVER;
            center_x_reg    <= 32'sd0;
            center_y_reg    <= 32'sd0;
            center_z_reg    <= 32'sd65536;
            radius_reg      <= 30'd65536;
            motion_step_reg <= 32'd10737418;
            line_length_reg <= 30'd131072;
            start_delay_reg <= 32'd20;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_MODE:        mode_reg        <= pwdata[1:0];
                REG_CENTER_X:    center_x_reg    <= $signed(pwdata);
                REG_CENTER_Y:    center_y_reg    <= $signed(pwdata);
                REG_CENTER_Z:    center_z_reg    <= $signed(pwdata);
                REG_RADIUS:      radius_reg      <= pwdata[29:0];
                REG_MOTION_STEP: motion_step_reg <= pwdata;
                REG_LINE_LENGTH: line_length_reg <= pwdata[29:0];
                REG_START_DELAY: start_delay_reg <= pwdata;
                default:         mode_reg        <= mode_reg;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (cfg_idx)
            REG_MODE:        prdata = {30'd0, mode_reg};
            REG_CENTER_X:    prdata = center_x_reg;
            REG_CENTER_Y:    prdata = center_y_reg;
            REG_CENTER_Z:    prdata = center_z_reg;
            REG_RADIUS:      prdata = {2'd0, radius_reg};
            REG_MOTION_STEP: prdata = motion_step_reg;
            REG_LINE_LENGTH: prdata = {2'd0, line_length_reg};
            REG_START_DELAY: prdata = start_delay_reg;
            default:         prdata = 32'd0;
        endcase
    end

endmodule

[tb/tb_trajectory_setpoint_generator_top.sv]
// ----------------------------------------------------------------------------
// tb_trajectory_setpoint_generator_top: self-checking bench for the setpoint
// generator
// Sends tick and restart requests under random gaps and output stalls. It
// changes the registers between phases and compares each setpoint request
// with a local model of the timeline, the circle trig and the line fold.
// ----------------------------------------------------------------------------
module tb_trajectory_setpoint_generator_top
    import tsg_pkg::*;
();

    localparam logic [1:0] MODE_HOVER_ALT = 2'd3;
    localparam int         CYCLE_LIMIT    = 400000;
    localparam int         HOLD_CYCLES    = 400;

    // Expected setpoints and the model of the timeline they come from
    class setpoint_scoreboard;
        logic [1:0]  mode;
        longint      cx;
        longint      cy;
        longint      cz;
        logic [31:0] radius;
        logic [31:0] step;
        logic [31:0] length;
        logic [31:0] delay;
        logic [31:0] ticks;
        logic [31:0] phase;
        logic [31:0] line_dist;
        logic [127:0] setpoint_q[$];
        int          errors;

        function new();
            mode      = MODE_HOVER;
            cx        = 0;
            cy        = 0;
            cz        = 65536;
            radius    = 65536;
            step      = 10737418;
            length    = 131072;
            delay     = 20;
            ticks     = 0;
            phase     = 0;
            line_dist = 0;
            errors    = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                REG_MODE:        mode   = v[1:0];
                REG_CENTER_X:    cx     = longint'($signed(v));
                REG_CENTER_Y:    cy     = longint'($signed(v));
                REG_CENTER_Z:    cz     = longint'($signed(v));
                REG_RADIUS:      radius = v & 32'h3FFF_FFFF;
                REG_MOTION_STEP: step   = v;
                REG_LINE_LENGTH: length = v & 32'h3FFF_FFFF;
                REG_START_DELAY: delay  = v;
                default: ;
            endcase
        endfunction

        function int pending();
            return setpoint_q.size();
        endfunction

        function longint clip_unit(longint v);
            if (v < 0)
                return 0;
            if (v > Q30_ONE)
                return Q30_ONE;
            return v;
        endfunction

        // Q30 sine and cosine of an angle in 2^-32 turns, series per quarter
        function void angle_trig(logic [31:0] turn, output longint sn, output longint cs);
            longint u;
            longint x;
            longint x2;
            longint t;
            longint qs;
            longint qc;
            int     i;
            u = longint'(turn[29:0]);
            x = u * HALF_PI_Q30 / Q30_ONE;
            x2 = x * x / Q30_ONE;
            t = Q30_ONE;
            for (i = 0; i < 6; i++)
            begin
                t = Q30_ONE - (x2 * t / Q30_ONE) / ((13 - 2 * i) * (12 - 2 * i));
            end
            qs = clip_unit(x * t / Q30_ONE);
            t = Q30_ONE;
            for (i = 0; i < 6; i++)
            begin
                t = Q30_ONE - (x2 * t / Q30_ONE) / ((12 - 2 * i) * (11 - 2 * i));
            end
            qc = clip_unit(t);
            case (turn[31:30])
                2'd0:    begin sn = qs;  cs = qc;  end
                2'd1:    begin sn = qc;  cs = -qs; end
                2'd2:    begin sn = -qs; cs = -qc; end
                default: begin sn = -qc; cs = qs;  end
            endcase
        endfunction

        // Shift right, rounding half away from zero
        function longint round_away(longint v, int sh);
            longint m;
            m = (v < 0) ? -v : v;
            m = (m + (64'sd1 << (sh - 1))) >> sh;
            return (v < 0) ? -m : m;
        endfunction

        function logic [31:0] clip_pos(longint v);
            longint hi;
            longint lo;
            longint r;
            hi = (64'sd1 << (POSITION_WIDTH - 1)) - 1;
            lo = -hi - 1;
            r = v;
            if (v > hi)
                r = hi;
            if (v < lo)
                r = lo;
            return r[31:0];
        endfunction

        function longint clip_q15(longint v);
            if (v > 32767)
                return 32767;
            if (v < -32768)
                return -32768;
            return v;
        endfunction

        // Advance the timeline by one accepted request
        function void note_tick(logic restart);
            logic [31:0] len;
            logic [31:0] two_len;
            logic [31:0] lstep;
            logic [31:0] f;
            logic [31:0] yaw;
            logic [31:0] half;
            longint      px;
            longint      py;
            longint      qz;
            longint      qw;
            longint      sn;
            longint      cs;
            longint      h;
            longint      off;
            if (restart)
            begin
                ticks     = 0;
                phase     = 0;
                line_dist = 0;
                return;
            end
            len = (length != 0) ? length : 32'd1;
            two_len = len * 2;
            phase = phase + step;
            if (line_dist >= two_len)
                line_dist = line_dist % two_len;
            lstep = (step < two_len) ? step : two_len - 1;
            line_dist = line_dist + lstep;
            if (line_dist >= two_len)
                line_dist = line_dist - two_len;
            if (ticks < delay)
                ticks = ticks + 1;
            else
                ticks = delay;
            if (ticks < delay)
                return;

            px = cx;
            py = cy;
            qz = 0;
            qw = 32767;
            if (mode == MODE_CIRCLE)
            begin
                // phase floored to a table step; yaw is a quarter turn ahead
                f = (phase >> (32 - PHASE_BITS)) << (32 - PHASE_BITS);
                yaw = f + 32'h4000_0000;
                angle_trig(f, sn, cs);
                px = cx + round_away(longint'(radius) * cs, 30);
                py = cy + round_away(longint'(radius) * sn, 30);
                if (yaw == 32'h8000_0000)
                    half = 32'h4000_0000;
                else if (yaw < 32'h8000_0000)
                    half = yaw >> 1;
                else
                    half = -((-yaw) >> 1);
                angle_trig(half, sn, cs);
                qz = clip_q15(round_away(sn, 15));
                qw = clip_q15(round_away(cs, 15));
                if (qw < 0)
                    qw = 0;
            end
            else if (mode == MODE_LINE)
            begin
                // back-and-forth fold about the centre
                h = longint'(len >> 1);
                if (longint'(line_dist) <= longint'(len))
                    off = longint'(line_dist) - h;
                else
                    off = (longint'(two_len) - longint'(line_dist)) - h;
                px = cx + off;
            end
            setpoint_q.push_back({1'b0, qw[14:0], qz[15:0],
                                  clip_pos(cz), clip_pos(py), clip_pos(px)});
        endfunction

        function void field_check(string name, longint want, longint got);
            if (want != got)
            begin
                $display("%0t: %s expected %0d got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_setpoint(logic [127:0] got);
            logic [127:0] want;
            if (setpoint_q.size() == 0)
            begin
                $display("%0t: setpoint expected none got %h", $time, got);
                errors++;
                return;
            end
            want = setpoint_q.pop_front();
            field_check("pos_x", $signed(want[31:0]), $signed(got[31:0]));
            field_check("pos_y", $signed(want[63:32]), $signed(got[63:32]));
            field_check("pos_z", $signed(want[95:64]), $signed(got[95:64]));
            field_check("quat_z", $signed(want[111:96]), $signed(got[111:96]));
            field_check("quat_w", want[126:112], got[126:112]);
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;    // [0] restart, [7:1] zero
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;    // pos_x, pos_y, pos_z, quat_z, quat_w, pad
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    setpoint_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_request;
    int hold_cycles;
    int cycle_count;

    trajectory_setpoint_generator_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Output side: random stalls, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            m_axis_tready <= 1'b0;
        end
        else if (hold_request)
        begin
            hold_request = 1'b0;
            hold_cycles = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: accepted ticks feed the model, accepted setpoints are checked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_tick(s_axis_tdata[0]);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_setpoint(m_axis_tdata);
        end
    end

    // APB write: setup then access, written when pready is seen
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    // Offer n tick requests, restart with the given percentage
    task automatic send_ticks(int n, int restart_pct);
        int  done_cnt;
        bit  busy;
        done_cnt = 0;
        busy = 1'b0;
        while (done_cnt < n)
        begin
            @(posedge clk);
            if (busy && s_axis_tready)
            begin
                done_cnt++;
                busy = 1'b0;
            end
            if (!busy && done_cnt < n && $urandom_range(99) >= send_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {7'd0, ($urandom_range(99) < restart_pct)};
                busy = 1'b1;
            end
            else if (!busy)
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    endtask

    // Wait for all setpoints, then let any no-output tick finish
    task automatic settle();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_centre();
        logic [31:0] v;
        int          r;
        r = $urandom_range(9);
        v = $urandom();
        if (r == 0)
            v = 32'h7FFF_FFFF;
        else if (r == 1)
            v = 32'h8000_0000;
        else if (r > 3)
            v = {{11{v[21]}}, v[20:0]};
        return v;
    endfunction

    task automatic random_setup();
        int          r;
        logic [31:0] v;
        write_reg(REG_MODE, $urandom_range(3));
        write_reg(REG_CENTER_X, pick_centre());
        write_reg(REG_CENTER_Y, pick_centre());
        write_reg(REG_CENTER_Z, pick_centre());
        r = $urandom_range(9);
        v = (r == 0) ? 32'd0 : (r == 1) ? 32'h3FFF_FFFF :
            (r == 2) ? ($urandom() & 32'h3FFF_FFFF) : $urandom_range(32'h3F_FFFF);
        write_reg(REG_RADIUS, v);
        r = $urandom_range(9);
        v = (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF :
            (r < 4) ? $urandom() : $urandom_range(32'h0400_0000);
        write_reg(REG_MOTION_STEP, v);
        r = $urandom_range(9);
        v = (r == 0) ? 32'd0 : (r == 1) ? 32'h3FFF_FFFF :
            (r == 2) ? $urandom_range(1, 8) : $urandom_range(1, 32'h0080_0000);
        write_reg(REG_LINE_LENGTH, v);
        r = $urandom_range(19);
        v = (r == 0) ? 32'hFFFF_FFFF : (r < 14) ? $urandom_range(3) : $urandom_range(4, 30);
        write_reg(REG_START_DELAY, v);
    endtask

    // Stimulus
    initial
    begin
        int total;
        int n;
        int phase_no;
        sb = new();
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'd0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= 5'd0;
        pwdata        <= 32'd0;
        m_axis_tready <= 1'b0;
        send_idle_pct = 27;
        recv_idle_pct = 27;
        hold_request  = 1'b0;
        hold_cycles   = 0;
        cycle_count   = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Defaults: still inside the start delay, then a restart
        send_ticks(2, 0);
        send_ticks(1, 100);
        settle();

        // Circle in quarter-turn steps: every quadrant, yaw at -pi, saturation
        write_reg(REG_START_DELAY, 32'd0);
        write_reg(REG_MODE, 32'(MODE_CIRCLE));
        write_reg(REG_RADIUS, 32'h3FFF_FFFF);
        write_reg(REG_CENTER_X, 32'h7FFF_FFFF);
        write_reg(REG_CENTER_Y, 32'h8000_0000);
        write_reg(REG_CENTER_Z, 32'd0);
        write_reg(REG_MOTION_STEP, 32'h4000_0000);
        send_ticks(4, 0);
        settle();

        // Line of zero length with the largest step
        write_reg(REG_MODE, 32'(MODE_LINE));
        write_reg(REG_LINE_LENGTH, 32'd0);
        write_reg(REG_MOTION_STEP, 32'hFFFF_FFFF);
        send_ticks(3, 0);
        settle();

        // Longest line, then shrunk so the distance is out of range
        write_reg(REG_LINE_LENGTH, 32'h3FFF_FFFF);
        send_ticks(3, 0);
        settle();
        write_reg(REG_LINE_LENGTH, 32'd5);
        send_ticks(2, 0);
        settle();

        // Mode 3 and plain hover at the negative extreme
        write_reg(REG_MODE, 32'(MODE_HOVER_ALT));
        write_reg(REG_CENTER_X, 32'h8000_0000);
        send_ticks(2, 0);
        settle();
        write_reg(REG_MODE, 32'(MODE_HOVER));
        send_ticks(1, 0);
        settle();

        // Longest delay, then lowered below the elapsed count
        write_reg(REG_START_DELAY, 32'hFFFF_FFFF);
        send_ticks(2, 0);
        settle();
        write_reg(REG_START_DELAY, 32'd1);
        send_ticks(2, 0);
        send_ticks(1, 100);
        send_ticks(2, 0);
        settle();

        // Random phases
        total = 0;
        phase_no = 0;
        while (total < 830)
        begin
            random_setup();
            n = $urandom_range(15, 50);
            send_idle_pct = 27;
            recv_idle_pct = 27;
            if (phase_no == 2)
            begin
                // no idling on either side
                send_idle_pct = 0;
                recv_idle_pct = 0;
                n = 120;
            end
            else if (phase_no == 5 || phase_no == 11)
            begin
                // output held off while ticks keep coming
                write_reg(REG_START_DELAY, 32'd0);
                send_idle_pct = 0;
                hold_request = 1'b1;
                n = 40;
            end
            send_ticks(n, 6);
            settle();
            total += n;
            phase_no++;
        end

        settle();
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
